// ----- hw/rtl/chce_pkg.sv -----
// Shared types, widths and helpers for the cubic heading curve evaluator.
// No dependencies; every module of the block imports this package.
package chce_pkg;

    localparam int COORD_W   = 32;
    localparam int HEAD_W    = 16;
    localparam int PARAM_W   = 17;
    localparam int FRAC_W    = 16;
    localparam int ORD_W     = 3;
    localparam int OUT_W     = 48;
    localparam int WIDE_W    = 52;
    localparam int DIFF_W    = 33;
    localparam int MA_W      = 48;
    localparam int MB_W      = 34;
    localparam int MH_W      = 17;
    localparam int PROD_W    = 82;
    localparam int RAD_W     = 68;
    localparam int ROOT_W    = 34;
    localparam int REM_W     = 38;
    localparam int SQRT_STEPS = 34;
    localparam int CORD_STEPS = 16;
    localparam int XY_W      = 34;
    localparam int Z_W       = 33;
    localparam int KT_W      = 37;
    localparam int CFG_IDX_W = 3;
    localparam logic [XY_W-1:0] CORDIC_GAIN = 34'd652032874;

    localparam logic [CFG_IDX_W-1:0] REG_START_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_H = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_END_H   = 3'd5;

    localparam logic [ORD_W-1:0] ORD_POS = 3'd0;
    localparam logic [ORD_W-1:0] ORD_D1  = 3'd1;
    localparam logic [ORD_W-1:0] ORD_D2  = 3'd2;
    localparam logic [ORD_W-1:0] ORD_D3  = 3'd3;

    typedef enum logic [4:0] {
        S_IDLE, S_SQ_DX, S_SQ_DX_W, S_SQ_DY, S_SQ_DY_W, S_SQRT, S_SQRT_W,
        S_COR, S_COR_W, S_KMUL, S_KMUL_W, S_COEF,
        S_Q_AXIS, S_Q_MUL, S_Q_MUL_W, S_Q_STORE, S_OUT
    } t_state;

    typedef struct packed {
        logic mul_start;
        logic sqrt_start;
        logic cor_start;
    } t_unit_ctl;

    // arctangent of 2^-i in 2^32 units per turn
    function automatic logic [31:0] atan_turn(input logic [3:0] i);
        logic [31:0] v;
        case (i)
            4'd0:  v = 32'h20000000;
            4'd1:  v = 32'h12E4051D;
            4'd2:  v = 32'h09FB385B;
            4'd3:  v = 32'h051111D4;
            4'd4:  v = 32'h028B0D43;
            4'd5:  v = 32'h0145D7E1;
            4'd6:  v = 32'h00A2F61E;
            4'd7:  v = 32'h00517C55;
            4'd8:  v = 32'h0028BE53;
            4'd9:  v = 32'h00145F2E;
            4'd10: v = 32'h000A2F98;
            4'd11: v = 32'h000517CC;
            4'd12: v = 32'h00028BE6;
            4'd13: v = 32'h000145F3;
            4'd14: v = 32'h0000A2F9;
            default: v = 32'h0000517C;
        endcase
        return v;
    endfunction

    function automatic logic signed [OUT_W-1:0] sat48(input logic signed [WIDE_W-1:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > $signed({{(WIDE_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}}))
            r = {1'b0, {(OUT_W-1){1'b1}}};
        else if (v < $signed({{(WIDE_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}}))
            r = {1'b1, {(OUT_W-1){1'b0}}};
        else
            r = v[OUT_W-1:0];
        return r;
    endfunction

endpackage

// ----- hw/rtl/cubic_heading_curve_eval.sv -----
// Cubic heading curve evaluator: top level with sequencer and coefficient store.
// Depends on chce_pkg, chce_mul, chce_sqrt and chce_cordic.
//
// The block holds a planar cubic set by its start and end points (Q16.16) and
// start and end headings (16-bit binary angle). A request carries t (Q1.16,
// values above 1.0 act as 1.0) and a derivative order; the result is the x,y
// position (order 0) or the first, second or third derivative in Q32.16,
// saturated, and zero for orders 4 to 7. Requests are taken one at a time:
// o_in_stall is low only while the sequencer is idle. All products run on
// one shared two-pass multiplier; each axis is evaluated by Horner's rule,
// and orders 3 and above need no products. The first request after reset or
// after any write to registers 0 to 5 also rederives the coefficients first:
// two squares, a bitwise square root, two 16-step CORDIC passes and four
// scaling products. A finished result waits in the output register while the
// next request is being taken.
module cubic_heading_curve_eval (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [chce_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [chce_pkg::COORD_W-1:0]          i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [chce_pkg::PARAM_W-1:0]          i_curve_param,
    input  logic [chce_pkg::ORD_W-1:0]            i_derivative_order,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [chce_pkg::OUT_W-1:0]     o_out_x,
    output logic signed [chce_pkg::OUT_W-1:0]     o_out_y
);
    import chce_pkg::*;

    t_state r_state, n_state;
    t_unit_ctl ctl;

    // control
    logic r_stale;
    logic r_ovalid;
    logic r_hsel;
    logic [1:0] r_kidx;
    logic r_axis;
    logic [1:0] r_j;
    logic [1:0] r_n;

    // payload
    logic signed [COORD_W-1:0] r_sx, r_sy, r_ex, r_ey;
    logic [HEAD_W-1:0]         r_h1, r_h2;
    logic signed [DIFF_W-1:0]  r_dx, r_dy;
    logic [RAD_W-1:0]          r_rad;
    logic [ROOT_W-1:0]         r_k;
    logic signed [XY_W-1:0]    r_cs [4];
    logic signed [KT_W-1:0]    r_kt [4];
    logic signed [OUT_W-1:0]   r_coef [8];
    logic [PARAM_W-1:0]        r_t;
    logic [ORD_W-1:0]          r_ord;
    logic signed [OUT_W-1:0]   r_acc;
    logic signed [OUT_W-1:0]   r_outx;
    logic signed [OUT_W-1:0]   r_oy;

    // shared units
    logic [MA_W-1:0]          mul_a;
    logic [MB_W-1:0]          mul_b;
    logic                     mul_done;
    logic [PROD_W-1:0]        mul_prod;
    logic                     sqrt_done;
    logic [ROOT_W-1:0]        sqrt_root;
    logic                     cor_done;
    logic signed [XY_W-1:0]   cor_cos, cor_sin;

    logic                     in_acc;
    logic                     out_free;
    logic                     cfg_hit;
    logic [2:0]               cidx;
    logic signed [OUT_W-1:0]  coef_rd;
    logic signed [WIDE_W-1:0] coef_w;
    logic signed [OUT_W-1:0]  add_v;
    logic signed [XY_W-1:0]   cs_sel;
    logic [XY_W-1:0]          cs_mag;
    logic [65:0]              kt_rnd;
    logic [63:0]              h_rnd;
    logic signed [OUT_W:0]    h_term;
    logic signed [WIDE_W-1:0] h_sum;
    logic [PARAM_W-1:0]       t_clip;
    logic signed [WIDE_W-1:0] dx_w, dy_w, kt0, kt1, kt2, kt3;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_ovalid || !i_out_stall;
    assign cfg_hit  = i_cfg_we && (i_cfg_index <= REG_END_H);

    // clamp t to 1.0
    assign t_clip = (i_curve_param[PARAM_W-1] && (i_curve_param[FRAC_W-1:0] != '0))
                  ? {1'b1, {FRAC_W{1'b0}}} : i_curve_param;

    // single read port into the coefficient store: c3 at init, else 2-j
    assign cidx    = (r_state == S_Q_AXIS) ? {2'd3, r_axis} : {2'd2 - r_j, r_axis};
    assign coef_rd = r_coef[cidx];
    assign coef_w  = WIDE_W'(coef_rd);
    assign add_v   = (r_j == 2'd0 && r_ord != ORD_POS) ? sat48(coef_w <<< 1) : coef_rd;

    assign cs_sel = r_cs[r_kidx];
    assign cs_mag = cs_sel[XY_W-1] ? XY_W'(-cs_sel) : XY_W'(cs_sel);

    // operand select for the shared multiplier
    always_comb begin
        case (r_state)
            S_SQ_DX: begin
                mul_a = MA_W'(r_dx[DIFF_W-1] ? -r_dx : r_dx);
                mul_b = MB_W'(r_dx[DIFF_W-1] ? -r_dx : r_dx);
            end
            S_SQ_DY: begin
                mul_a = MA_W'(r_dy[DIFF_W-1] ? -r_dy : r_dy);
                mul_b = MB_W'(r_dy[DIFF_W-1] ? -r_dy : r_dy);
            end
            S_KMUL: begin
                mul_a = MA_W'(cs_mag);
                mul_b = r_k;
            end
            default: begin
                mul_a = r_acc[OUT_W-1] ? MA_W'(-r_acc) : MA_W'(r_acc);
                mul_b = MB_W'(r_t);
            end
        endcase
    end

    // products rounded half away from zero
    assign kt_rnd = mul_prod[65:0] + 66'(1 << 29);
    assign h_rnd  = mul_prod[63:0] + 64'(1 << (FRAC_W - 1));
    assign h_term = r_acc[OUT_W-1] ? -$signed({1'b0, h_rnd[63:FRAC_W]})
                                   : $signed({1'b0, h_rnd[63:FRAC_W]});
    assign h_sum  = WIDE_W'(add_v) + WIDE_W'(h_term);

    assign dx_w = WIDE_W'(r_dx);
    assign dy_w = WIDE_W'(r_dy);
    assign kt0  = WIDE_W'(r_kt[0]);
    assign kt1  = WIDE_W'(r_kt[1]);
    assign kt2  = WIDE_W'(r_kt[2]);
    assign kt3  = WIDE_W'(r_kt[3]);

    chce_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ctl.mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    chce_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ctl.sqrt_start),
        .i_rad   (r_rad),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    chce_cordic u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (ctl.cor_start),
        .i_heading (r_hsel ? r_h2 : r_h1),
        .o_done    (cor_done),
        .o_cos     (cor_cos),
        .o_sin     (cor_sin)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (in_acc) n_state = r_stale ? S_SQ_DX : S_Q_AXIS;
            S_SQ_DX:   n_state = S_SQ_DX_W;
            S_SQ_DX_W: if (mul_done) n_state = S_SQ_DY;
            S_SQ_DY:   n_state = S_SQ_DY_W;
            S_SQ_DY_W: if (mul_done) n_state = S_SQRT;
            S_SQRT:    n_state = S_SQRT_W;
            S_SQRT_W:  if (sqrt_done) n_state = S_COR;
            S_COR:     n_state = S_COR_W;
            S_COR_W:   if (cor_done) n_state = r_hsel ? S_KMUL : S_COR;
            S_KMUL:    n_state = S_KMUL_W;
            S_KMUL_W:  if (mul_done) n_state = (r_kidx == 2'd3) ? S_COEF : S_KMUL;
            S_COEF:    n_state = S_Q_AXIS;
            S_Q_AXIS:  n_state = (r_ord <= ORD_D2) ? S_Q_MUL : S_Q_STORE;
            S_Q_MUL:   n_state = S_Q_MUL_W;
            S_Q_MUL_W: if (mul_done) n_state = (r_n == 2'd1) ? S_Q_STORE : S_Q_MUL;
            S_Q_STORE: n_state = r_axis ? S_OUT : S_Q_AXIS;
            S_OUT:     if (out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // unit strobes
    always_comb begin
        ctl = '0;
        case (r_state)
            S_SQ_DX, S_SQ_DY, S_KMUL, S_Q_MUL: ctl.mul_start = 1'b1;
            S_SQRT:  ctl.sqrt_start = 1'b1;
            S_COR:   ctl.cor_start  = 1'b1;
            default: ctl = '0;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_stale  <= 1'b1;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            // any write to registers 0 to 5 forces a rederive; it wins over the clear
            if (cfg_hit)                 r_stale <= 1'b1;
            else if (r_state == S_COEF)  r_stale <= 1'b0;
            if (r_state == S_OUT && out_free) r_ovalid <= 1'b1;
            else if (!i_out_stall)            r_ovalid <= 1'b0;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx <= '0;
            r_sy <= '0;
            r_ex <= '0;
            r_ey <= '0;
            r_h1 <= '0;
            r_h2 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_START_X: r_sx <= i_cfg_data;
                REG_START_Y: r_sy <= i_cfg_data;
                REG_END_X:   r_ex <= i_cfg_data;
                REG_END_Y:   r_ey <= i_cfg_data;
                REG_START_H: r_h1 <= i_cfg_data[HEAD_W-1:0];
                REG_END_H:   r_h2 <= i_cfg_data[HEAD_W-1:0];
                default:     ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_t    <= t_clip;
                r_ord  <= i_derivative_order;
                r_dx   <= DIFF_W'(r_ex) - DIFF_W'(r_sx);
                r_dy   <= DIFF_W'(r_ey) - DIFF_W'(r_sy);
                r_hsel <= 1'b0;
                r_kidx <= 2'd0;
                r_axis <= 1'b0;
            end
            S_SQ_DX_W: if (mul_done) r_rad <= mul_prod[RAD_W-1:0];
            S_SQ_DY_W: if (mul_done) r_rad <= r_rad + mul_prod[RAD_W-1:0];
            S_SQRT_W:  if (sqrt_done) r_k <= sqrt_root;
            S_COR_W: begin
                if (cor_done) begin
                    r_cs[{r_hsel, 1'b0}] <= cor_cos;
                    r_cs[{r_hsel, 1'b1}] <= cor_sin;
                    r_hsel <= 1'b1;
                end
            end
            S_KMUL_W: begin
                if (mul_done) begin
                    r_kt[r_kidx] <= cs_sel[XY_W-1] ? -$signed({1'b0, kt_rnd[65:30]})
                                                   : $signed({1'b0, kt_rnd[65:30]});
                    r_kidx <= r_kidx + 2'd1;
                end
            end
            S_COEF: begin
                r_coef[0] <= OUT_W'(r_sx);
                r_coef[1] <= OUT_W'(r_sy);
                r_coef[2] <= sat48(kt0);
                r_coef[3] <= sat48(kt1);
                r_coef[4] <= sat48(dx_w + (dx_w <<< 1) - (kt0 <<< 1) - kt2);
                r_coef[5] <= sat48(dy_w + (dy_w <<< 1) - (kt1 <<< 1) - kt3);
                r_coef[6] <= sat48(kt0 + kt2 - (dx_w <<< 1));
                r_coef[7] <= sat48(kt1 + kt3 - (dy_w <<< 1));
            end
            S_Q_AXIS: begin
                r_j <= 2'd0;
                r_n <= 2'd3 - r_ord[1:0];
                case (r_ord)
                    ORD_POS: r_acc <= coef_rd;
                    ORD_D1:  r_acc <= sat48(coef_w + (coef_w <<< 1));
                    ORD_D2, ORD_D3: r_acc <= sat48((coef_w <<< 2) + (coef_w <<< 1));
                    default: r_acc <= '0;
                endcase
            end
            S_Q_MUL_W: begin
                if (mul_done) begin
                    r_acc <= sat48(h_sum);
                    r_j   <= r_j + 2'd1;
                    r_n   <= r_n - 2'd1;
                end
            end
            S_Q_STORE: begin
                if (!r_axis) r_outx <= r_acc;
                else         r_oy   <= r_acc;
                r_axis <= 1'b1;
            end
            S_OUT: begin
                if (out_free) begin
                    o_out_x <= r_outx;
                    o_out_y <= r_oy;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_ovalid;

    // a unit must only report completion while the sequencer is busy
    a_no_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !(mul_done || sqrt_done || cor_done))
        else $error("shared unit finished while idle");

    // accepted request leaves idle at once
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != S_IDLE))
        else $error("request accepted but sequencer idle");

    // coefficients become fresh only through the coefficient update
    a_stale_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_stale) |-> ($past(r_state) == S_COEF))
        else $error("stale flag cleared outside coefficient update");

    // a result is never loaded over one that is still stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_out_stall) |=> $stable(o_out_x) && $stable(o_out_y))
        else $error("pending result overwritten");

endmodule

// ----- hw/rtl/chce_mul.sv -----
// Two-pass unsigned multiplier: 48-bit operand times 34-bit operand.
// Uses one 48x17 multiplier for both passes, low half first. Depends on chce_pkg.
module chce_mul (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [chce_pkg::MA_W-1:0]    i_a,
    input  logic [chce_pkg::MB_W-1:0]    i_b,
    output logic                         o_done,
    output logic [chce_pkg::PROD_W-1:0]  o_prod
);
    import chce_pkg::*;

    logic [1:0]            r_ph;
    logic                  r_done;
    logic [MA_W-1:0]       r_a;
    logic [MB_W-1:0]       r_b;
    logic [MA_W+MH_W-1:0]  r_lo;
    logic [PROD_W-1:0]     r_prod;
    logic [MH_W-1:0]       half;
    logic [MA_W+MH_W-1:0]  pp;

    assign half = (r_ph == 2'd1) ? r_b[MH_W-1:0] : r_b[MB_W-1:MH_W];
    assign pp   = {{MH_W{1'b0}}, r_a} * {{MA_W{1'b0}}, half};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= 2'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_ph == 2'd2);
            case (r_ph)
                2'd0: r_ph <= i_start ? 2'd1 : 2'd0;
                2'd1: r_ph <= 2'd2;
                default: r_ph <= 2'd0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && r_ph == 2'd0) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        if (r_ph == 2'd1) r_lo <= pp;
        if (r_ph == 2'd2)
            r_prod <= {{MH_W{1'b0}}, r_lo} + {pp, {MH_W{1'b0}}};
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

// ----- hw/rtl/chce_sqrt.sv -----
// Bitwise integer square root, two radicand bits per cycle.
// Depends on chce_pkg.
module chce_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [chce_pkg::RAD_W-1:0]  i_rad,
    output logic                        o_done,
    output logic [chce_pkg::ROOT_W-1:0] o_root
);
    import chce_pkg::*;

    logic [5:0]        r_cnt;
    logic              r_done;
    logic [RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [REM_W-1:0]  rem_n;
    logic [REM_W-1:0]  trial;

    assign rem_n = {r_rem[REM_W-3:0], r_rad[RAD_W-1:RAD_W-2]};
    assign trial = {{(REM_W-ROOT_W-2){1'b0}}, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 6'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == 6'd1);
            if (i_start && r_cnt == 6'd0) r_cnt <= 6'(SQRT_STEPS);
            else if (r_cnt != 6'd0)       r_cnt <= r_cnt - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && r_cnt == 6'd0) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_cnt != 6'd0) begin
            r_rad <= {r_rad[RAD_W-3:0], 2'b00};
            if (rem_n >= trial) begin
                r_rem  <= rem_n - trial;
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_n;
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ----- hw/rtl/chce_cordic.sv -----
// Rotation CORDIC: unit cosine and sine of a 16-bit binary angle, Q4.30.
// One micro-rotation per cycle after quadrant reduction. Depends on chce_pkg.
module chce_cordic (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [chce_pkg::HEAD_W-1:0]       i_heading,
    output logic                              o_done,
    output logic signed [chce_pkg::XY_W-1:0]  o_cos,
    output logic signed [chce_pkg::XY_W-1:0]  o_sin
);
    import chce_pkg::*;

    logic                   r_busy;
    logic                   r_done;
    logic [3:0]             r_i;
    logic [1:0]             r_q;
    logic signed [XY_W-1:0] r_x, r_y;
    logic signed [Z_W-1:0]  r_z;
    logic [HEAD_W-1:0]      hsum, hred;
    logic signed [XY_W-1:0] xs, ys;
    logic signed [Z_W-1:0]  at;

    assign hsum = i_heading + 16'h2000;
    assign hred = i_heading - {hsum[15:14], 14'd0};
    assign xs   = r_x >>> r_i;
    assign ys   = r_y >>> r_i;
    assign at   = $signed({1'b0, atan_turn(r_i)});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= 4'd0;
        end else begin
            r_done <= r_busy && (r_i == 4'(CORD_STEPS - 1));
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_i    <= 4'd0;
            end else if (r_busy) begin
                r_i <= r_i + 4'd1;
                if (r_i == 4'(CORD_STEPS - 1)) r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_q <= hsum[15:14];
            r_x <= CORDIC_GAIN;
            r_y <= '0;
            r_z <= $signed({hred[15], hred, 16'd0});
        end else if (r_busy) begin
            if (!r_z[Z_W-1]) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + at;
            end
        end
    end

    // map the first-quadrant result back to the original quadrant
    always_comb begin
        case (r_q)
            2'd0:    begin o_cos = r_x;  o_sin = r_y;  end
            2'd1:    begin o_cos = -r_y; o_sin = r_x;  end
            2'd2:    begin o_cos = -r_x; o_sin = -r_y; end
            default: begin o_cos = r_y;  o_sin = -r_x; end
        endcase
    end

    assign o_done = r_done;

endmodule

// ----- dv/cubic_heading_curve_eval_tb.sv -----
// Testbench for cubic_heading_curve_eval: directed and random requests checked
// against a cycle-free predictor of the curve math. Depends on chce_pkg and the RTL.
`timescale 1ns / 100ps

module cubic_heading_curve_eval_tb;
    import chce_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 300;
    localparam longint MAX48 = (longint'(1) <<< 47) - 1;
    localparam longint MIN48 = -(longint'(1) <<< 47);

    typedef struct packed {
        logic [OUT_W-1:0] x;
        logic [OUT_W-1:0] y;
    } t_point;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [COORD_W-1:0]   i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [PARAM_W-1:0]   i_curve_param = '0;
    logic [ORD_W-1:0]     i_derivative_order = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic signed [OUT_W-1:0] o_out_x;
    logic signed [OUT_W-1:0] o_out_y;

    // Predictor state: register images, coefficients, stale flag
    logic [COORD_W-1:0] cfg_word [6];
    longint             coef [8];
    bit                 coef_stale;

    t_point expected_points [$];
    int     mismatch_count = 0;
    int     idle_cycles = 0;
    bit     gaps_on = 1'b0;
    int     hold_token = 0;
    int     hold_seen = 0;
    int     stall_left = 0;

    // arctangent of 2^-i, 2^32 units per turn
    longint arctan_step [16] = '{
        64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2E, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C
    };

    cubic_heading_curve_eval DUT (.*);

    always #5 i_clk = ~i_clk;

    function automatic longint clamp48(input longint v);
        if (v > MAX48) return MAX48;
        if (v < MIN48) return MIN48;
        return v;
    endfunction

    // (a*b) >> sh, half away from zero, magnitude capped at 2^62
    function automatic longint scaled_round(input longint a, input longint b, input int sh);
        logic [63:0]  m;
        logic [127:0] p;
        longint       r;
        m = (a < 0) ? 64'(-a) : 64'(a);
        p = {64'b0, m} * {64'b0, 64'(b)};
        p = (p + (128'd1 << (sh - 1))) >> sh;
        if (p > (128'd1 << 62)) p = 128'd1 << 62;
        r = longint'(p[63:0]);
        return (a < 0) ? -r : r;
    endfunction

    // unit heading vector in Q2.30, rotated from the nearest quadrant
    task automatic heading_vector(input logic [15:0] h, output longint c, output longint s);
        logic [16:0] biased;
        logic [1:0]  quad;
        logic [15:0] resid;
        longint      x, y, z, nx;
        biased = {1'b0, h} + 17'h2000;
        quad   = biased[15:14];
        resid  = h - {quad, 14'b0};
        z = longint'($signed(resid)) * 65536;
        x = 652032874;
        y = 0;
        for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i); y = y + (x >>> i); z -= arctan_step[i];
            end else begin
                nx = x + (y >>> i); y = y - (x >>> i); z += arctan_step[i];
            end
            x = nx;
        end
        case (quad)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    task automatic derive_coefficients();
        longint       sx, sy, dx, dy, k, c1, s1, c2, s2, kc1, ks1, kc2, ks2;
        logic [63:0]  mx, my;
        logic [127:0] radicand, rem, root, trial;
        sx = longint'($signed(cfg_word[REG_START_X]));
        sy = longint'($signed(cfg_word[REG_START_Y]));
        dx = longint'($signed(cfg_word[REG_END_X])) - sx;
        dy = longint'($signed(cfg_word[REG_END_Y])) - sy;
        mx = (dx < 0) ? 64'(-dx) : 64'(dx);
        my = (dy < 0) ? 64'(-dy) : 64'(dy);
        radicand = {64'b0, mx} * {64'b0, mx} + {64'b0, my} * {64'b0, my};
        rem = '0;
        root = '0;
        // bitwise square root, two radicand bits per step
        for (int i = 33; i >= 0; i--) begin
            rem = (rem << 2) | ((radicand >> (2 * i)) & 128'd3);
            trial = (root << 2) | 128'd1;
            if (rem >= trial) begin
                rem = rem - trial;
                root = (root << 1) | 128'd1;
            end else begin
                root = root << 1;
            end
        end
        k = longint'(root[63:0]);
        heading_vector(cfg_word[REG_START_H][15:0], c1, s1);
        heading_vector(cfg_word[REG_END_H][15:0], c2, s2);
        kc1 = scaled_round(c1, k, 30); ks1 = scaled_round(s1, k, 30);
        kc2 = scaled_round(c2, k, 30); ks2 = scaled_round(s2, k, 30);
        coef[0] = clamp48(sx);
        coef[1] = clamp48(sy);
        coef[2] = clamp48(kc1);
        coef[3] = clamp48(ks1);
        coef[4] = clamp48(3 * dx - 2 * kc1 - kc2);
        coef[5] = clamp48(3 * dy - 2 * ks1 - ks2);
        coef[6] = clamp48(-2 * dx + kc1 + kc2);
        coef[7] = clamp48(-2 * dy + ks1 + ks2);
    endtask

    function automatic longint horner_stage(input longint acc, input longint t, input longint add);
        return clamp48(add + scaled_round(acc, t, FRAC_W));
    endfunction

    function automatic longint axis_value(input int axis, input logic [ORD_W-1:0] ord,
                                          input longint t);
        longint a0, a1, a2, a3, acc;
        a0 = coef[axis]; a1 = coef[2 + axis]; a2 = coef[4 + axis]; a3 = coef[6 + axis];
        case (ord)
            ORD_POS: begin
                acc = horner_stage(a3, t, a2);
                acc = horner_stage(acc, t, a1);
                return horner_stage(acc, t, a0);
            end
            ORD_D1: begin
                acc = horner_stage(clamp48(3 * a3), t, clamp48(2 * a2));
                return horner_stage(acc, t, a1);
            end
            ORD_D2: return horner_stage(clamp48(6 * a3), t, clamp48(2 * a2));
            ORD_D3: return clamp48(6 * a3);
            default: return 0;
        endcase
    endfunction

    // advance the predictor by one accepted request
    task automatic predict_point(input logic [PARAM_W-1:0] tp, input logic [ORD_W-1:0] ord);
        longint t;
        t_point p;
        longint vx, vy;
        if (coef_stale) begin
            derive_coefficients();
            coef_stale = 1'b0;
        end
        t = (tp > (1 << FRAC_W)) ? (1 << FRAC_W) : longint'(tp);
        vx = axis_value(0, ord, t);
        vy = axis_value(1, ord, t);
        p.x = vx[OUT_W-1:0];
        p.y = vy[OUT_W-1:0];
        expected_points.push_back(p);
    endtask

    // Send one request; valid stays high afterwards so back-to-back requests
    // never lower and raise it in one step.
    task automatic send_request(input logic [PARAM_W-1:0] tp, input logic [ORD_W-1:0] ord);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_curve_param <= tp;
        i_derivative_order <= ord;
        do @(posedge i_clk); while (o_in_stall);
        predict_point(tp, ord);
    endtask

    // Drop valid and hold until every expected result is back, plus a margin.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Write one register; the enable drops for a cycle before the next write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx <= REG_END_H) begin
            cfg_word[idx] = (idx < REG_START_H) ? data : {16'b0, data[15:0]};
            coef_stale = 1'b1;
        end
        @(posedge i_clk);
    endtask

    task automatic load_curve(input logic [31:0] sx, input logic [31:0] sy,
                              input logic [31:0] ex, input logic [31:0] ey,
                              input logic [31:0] sh, input logic [31:0] eh);
        write_reg(REG_START_X, sx);
        write_reg(REG_START_Y, sy);
        write_reg(REG_END_X, ex);
        write_reg(REG_END_Y, ey);
        write_reg(REG_START_H, sh);
        write_reg(REG_END_H, eh);
    endtask

    function automatic logic [31:0] random_coord();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return 32'($signed($urandom_range(0, 400 << 16)) - (200 << 16));
    endfunction

    function automatic logic [PARAM_W-1:0] random_param();
        case ($urandom_range(0, 9))
            0: return PARAM_W'($urandom_range(65537, 131071));
            1: return $urandom_range(0, 1) ? 17'd65536 : 17'd0;
            default: return PARAM_W'($urandom_range(0, 65536));
        endcase
    endfunction

    // Zero coefficients straight after reset, every order.
    task automatic test_reset_state();
        for (int o = 0; o < 8; o++) send_request(17'd32768, ORD_W'(o));
        drain();
    endtask

    // Parameter extremes, every order, quadrant boundaries and saturation.
    task automatic test_directed();
        load_curve(32'h0000_0000, 32'h0000_0000, 32'h000A_0000, 32'h0005_0000,
                   32'hABCD_2000, 32'h0000_E000);
        write_reg(3'd6, 32'hFFFF_FFFF);   // out-of-range index, ignore
        write_reg(3'd7, 32'h1234_5678);
        send_request(17'd0, ORD_POS);
        send_request(17'd65536, ORD_POS);
        send_request(17'h1FFFF, ORD_POS); // above one clamps to one
        send_request(17'd1, ORD_D1);
        send_request(17'd32768, ORD_D2);
        send_request(17'd65535, ORD_D3);
        send_request(17'd40000, 3'd4);
        send_request(17'd40000, 3'd7);
        drain();
        // headings on rounding edges of the quadrant choice
        load_curve(32'hFFF0_0000, 32'h0003_0000, 32'h0001_8000, 32'hFFFF_0001,
                   32'h0000_6000, 32'h0000_A000);
        send_request(17'd16384, ORD_POS);
        send_request(17'd49152, ORD_D1);
        send_request(17'd65536, ORD_D2);
        drain();
        // farthest points: coefficients and sums hit the saturation limits
        load_curve(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h0000_FFFF, 32'h0000_8000);
        for (int o = 0; o < 4; o++) send_request(17'd65536, ORD_W'(o));
        send_request(17'd12345, ORD_POS);
        drain();
    endtask

    // Hold the output a long time while requests keep coming, then pause the
    // sender until everything is back.
    task automatic test_backpressure();
        load_curve(random_coord(), random_coord(), random_coord(), random_coord(),
                   $urandom, $urandom);
        hold_token++;
        for (int n = 0; n < 20; n++)
            send_request(random_param(), ORD_W'($urandom_range(0, 7)));
        drain();
    endtask

    // Random curves in phases, random requests between them.
    task automatic test_random();
        for (int ph = 0; ph < 17; ph++) begin
            gaps_on = (ph < 14);
            if (ph != 5)
                load_curve(random_coord(), random_coord(), random_coord(), random_coord(),
                           $urandom, $urandom);
            if (ph == 9) write_reg(REG_END_H, $urandom); // single register change
            for (int n = 0; n < 100; n++)
                send_request(random_param(), ORD_W'($urandom_range(0, 7)));
            drain();
        end
    endtask

    // Receiver: random stall bursts, one long hold per token, none at the end.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            i_out_stall <= 1'b1;
            stall_left <= LONG_HOLD;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 8);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Compare each delivered point with the oldest prediction.
    always @(posedge i_clk) begin
        t_point want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_points.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result x=%h y=%h", o_out_x, o_out_y);
            end else begin
                want = expected_points.pop_front();
                if (o_out_x !== want.x || o_out_y !== want.y) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected x=%h y=%h, got x=%h y=%h",
                                 want.x, want.y, o_out_x, o_out_y);
                end
            end
        end
    end

    // Watchdog: end the run if no request moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < 6; i++) cfg_word[i] = '0;
        for (int i = 0; i < 8; i++) coef[i] = 0;
        coef_stale = 1'b1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_directed();
        test_backpressure();
        test_random();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && expected_points.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
